>>> hdl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared sizes, command and register codes and the stored record types of
// the codebook background model.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam int unsigned PIXELS        = 65536;
  localparam int unsigned MAX_ENTRIES   = 8;
  localparam int unsigned CHANNELS_USED = 3;

  localparam int unsigned NCH    = 3;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned ENT_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW_AW  = PIX_AW + ENT_AW;
  localparam int unsigned CW_DEPTH = PIXELS * (2 ** ENT_AW);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CH_W-1:0]   CHAN_MAX = 8'd255;

  // Commands.
  localparam logic [1:0] CMD_LEARN  = 2'd0;
  localparam logic [1:0] CMD_DETECT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEARN_BOUND = 2'd0;
  localparam logic [1:0] REG_MIN_MOD     = 2'd1;
  localparam logic [1:0] REG_MAX_MOD     = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] tm;
  } pix_t;

  typedef struct packed {
    logic [NCH-1:0][CH_W-1:0] lhi;
    logic [NCH-1:0][CH_W-1:0] llo;
    logic [NCH-1:0][CH_W-1:0] bmax;
    logic [NCH-1:0][CH_W-1:0] bmin;
    logic [TIME_W-1:0]        lu;
    logic [TIME_W-1:0]        st;
  } cw_t;

endpackage

`default_nettype wire

>>> hdl/cbm_pix_mem.sv
// ----------------------------------------------------------------------------
// cbm_pix_mem
// Per-pixel store of codeword count and pixel time, with a zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_pix_mem import cbm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [PIX_AW-1:0] waddr_i,
  input  wire pix_t              wdata_i,
  input  wire logic [PIX_AW-1:0] raddr_i,
  output pix_t                   rdata_o,
  output logic                   ready_o
);

  pix_t              mem [PIXELS];
  pix_t              rdata_q;
  logic [PIX_AW:0]   sweep_q;
  logic              busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else if (busy_q) begin
      sweep_q <= sweep_q + 1'b1;
      if (sweep_q == (PIX_AW + 1)'(PIXELS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[sweep_q[PIX_AW-1:0]] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !busy_q;

endmodule

`default_nettype wire

>>> hdl/cbm_cw_mem.sv
// ----------------------------------------------------------------------------
// cbm_cw_mem
// Codeword store: one record per codeword slot, one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_cw_mem import cbm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [CW_AW-1:0] waddr_i,
  input  wire cw_t              wdata_i,
  input  wire logic [CW_AW-1:0] raddr_i,
  output cw_t                   rdata_o
);

  cw_t mem [CW_DEPTH];
  cw_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/codebook_background_model_unit.sv
// ----------------------------------------------------------------------------
// codebook_background_model_unit
// Per-pixel codebook background model: learn, detect and clear commands over
// a pixel's codewords held in a synchronous codeword memory.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Beat contents
//   in        input      in_valid_i / in_stall_o   command, pixel, 3 channels
//   out       output     out_valid_o / out_stall_i entry, fg, cleared, ovf
//   cfg       input      cfg_we_i                  register index and data
//
// An item runs through the states in order: the pixel record read, a visit
// to each of the pixel's codewords in the codeword memory (read of the
// next slot overlaps the write-back of the current one), a close, and back
// in idle, where the next beat is taken. Detect stops at the first covering
// codeword. After reset the pixel store is swept to zero, during which
// in_stall_o stays high. A result waits in the output register while the
// out side stalls; the next item can be accepted meanwhile, but it does not
// complete until that result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module codebook_background_model_unit import cbm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] pixel_index_i,
  input  wire logic [7:0]  chan_a_i,
  input  wire logic [7:0]  chan_b_i,
  input  wire logic [7:0]  chan_c_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       entry_index_o,
  output logic             foreground_o,
  output logic [3:0]       cleared_count_o,
  output logic             overflow_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PIX  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Configuration registers.
  logic [7:0]        learn_bound_q;
  logic signed [8:0] min_mod_q, max_mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_bound_q <= 8'd10;
      min_mod_q     <= 9'sd10;
      max_mod_q     <= 9'sd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEARN_BOUND: learn_bound_q <= cfg_data_i[7:0];
        REG_MIN_MOD:     min_mod_q     <= cfg_data_i;
        REG_MAX_MOD:     max_mod_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and item state.
  logic [1:0]               state_q, state_d;
  logic [1:0]               cmd_q;
  logic                     skip_q;
  logic [PIX_AW-1:0]        pix_q;
  logic [NCH-1:0][CH_W-1:0] p_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic [CNT_W-1:0]         hit_q, hit_d;
  logic                     found_q, found_d;
  logic                     fg_q, fg_d;
  logic [TIME_W-1:0]        t_q, t_d;
  logic [TIME_W-1:0]        thresh_q, thresh_d;

  // Output register.
  logic       out_valid_q;
  logic [2:0] entry_index_q;
  logic       foreground_q;
  logic [3:0] cleared_q;
  logic       overflow_q;

  // Memory ports.
  logic              pix_we, pix_ready;
  logic [PIX_AW-1:0] pix_raddr;
  pix_t              pix_wdata, pix_rdata;
  logic              cw_we;
  logic [CW_AW-1:0]  cw_waddr, cw_raddr;
  cw_t               cw_wdata, cw_rdata;

  logic in_accept, out_free, finish;
  logic [NCH-1:0][CH_W-1:0] hi, lo;

  assign in_stall_o = (state_q != S_IDLE) || !pix_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_FIN) && out_free;
  assign pix_raddr  = (state_q == S_IDLE) ? pixel_index_i[PIX_AW-1:0] : pix_q;

  // Learn box that the pixel pulls towards, clamped to the channel range.
  always_comb begin
    logic [CH_W:0] sum;
    for (int n = 0; n < NCH; n++) begin
      sum   = {1'b0, p_q[n]} + {1'b0, learn_bound_q};
      hi[n] = sum[CH_W] ? CHAN_MAX : sum[CH_W-1:0];
      lo[n] = (p_q[n] > learn_bound_q) ? p_q[n] - learn_bound_q : '0;
    end
  end

  // Main sequencer: read pixel record, visit codewords, write back, close.
  always_comb begin
    logic [CNT_W-1:0]     cnt_rd;
    logic [TIME_W-1:0]    tm0;
    logic [CNT_W-1:0]     idx_nx;
    logic                 learn_hit, box_hit, keep;
    logic [TIME_W-1:0]    run;
    logic signed [10:0]   v, lim_lo, lim_hi;
    cw_t                  cw;

    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    k_d      = k_q;
    hit_d    = hit_q;
    found_d  = found_q;
    fg_d     = fg_q;
    t_d      = t_q;
    thresh_d = thresh_q;
    cw_we    = 1'b0;
    cw_waddr = {pix_q, idx_q[ENT_AW-1:0]};
    cw_wdata = cw_rdata;
    cw_raddr = {pix_q, idx_q[ENT_AW-1:0]};
    pix_we   = 1'b0;
    pix_wdata = '0;
    cnt_rd   = (pix_rdata.cnt > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : pix_rdata.cnt;
    tm0      = (cnt_rd == '0) ? '0 : pix_rdata.tm;
    idx_nx   = idx_q + 1'b1;
    cw       = cw_rdata;
    learn_hit = 1'b1;
    box_hit   = 1'b1;
    keep      = (cw_rdata.st <= thresh_q);
    run       = (t_q >= cw_rdata.lu) ? t_q - cw_rdata.lu : '0;
    v = '0;
    lim_lo = '0;
    lim_hi = '0;

    for (int n = 0; n < CHANNELS_USED; n++) begin
      if (!(cw_rdata.llo[n] <= p_q[n] && p_q[n] <= cw_rdata.lhi[n])) begin
        learn_hit = 1'b0;
      end
      v      = $signed({3'b000, p_q[n]});
      lim_lo = $signed({3'b000, cw_rdata.bmin[n]}) - {{2{min_mod_q[8]}}, min_mod_q};
      lim_hi = $signed({3'b000, cw_rdata.bmax[n]}) + {{2{max_mod_q[8]}}, max_mod_q};
      if (!(lim_lo <= v && v <= lim_hi)) begin
        box_hit = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_PIX;
          found_d = 1'b0;
          fg_d    = 1'b1;
          k_d     = '0;
          hit_d   = '0;
          idx_d   = '0;
        end
      end
      S_PIX: begin
        cnt_d    = cnt_rd;
        t_d      = (tm0 == TIME_MAX) ? tm0 : tm0 + 1'b1;
        thresh_d = pix_rdata.tm >> 1;
        cw_raddr = {pix_q, {ENT_AW{1'b0}}};
        state_d  = (skip_q || cnt_rd == '0) ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        cw_raddr = {pix_q, idx_nx[ENT_AW-1:0]};
        idx_d    = idx_nx;
        if (idx_nx == cnt_q) begin
          state_d = S_FIN;
        end
        case (cmd_q)
          CMD_LEARN: begin
            cw_we = 1'b1;
            if (!found_q && learn_hit) begin
              found_d = 1'b1;
              hit_d   = idx_q;
              cw.lu   = t_q;
              for (int n = 0; n < CHANNELS_USED; n++) begin
                if (cw_rdata.bmax[n] < p_q[n]) begin
                  cw.bmax[n] = p_q[n];
                end else if (cw_rdata.bmin[n] > p_q[n]) begin
                  cw.bmin[n] = p_q[n];
                end
                if (cw_rdata.lhi[n] < hi[n]) begin
                  cw.lhi[n] = cw_rdata.lhi[n] + 1'b1;
                end
                if (cw_rdata.llo[n] > lo[n]) begin
                  cw.llo[n] = cw_rdata.llo[n] - 1'b1;
                end
              end
            end else if (cw_rdata.st < run) begin
              cw.st = run;
            end
            cw_wdata = cw;
          end
          CMD_DETECT: begin
            if (box_hit) begin
              fg_d    = 1'b0;
              state_d = S_FIN;
            end
          end
          CMD_CLEAR: begin
            if (keep) begin
              cw.st    = '0;
              cw.lu    = '0;
              cw_we    = 1'b1;
              cw_waddr = {pix_q, k_q[ENT_AW-1:0]};
              cw_wdata = cw;
              k_d      = k_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (!skip_q) begin
            case (cmd_q)
              CMD_LEARN: begin
                pix_we = 1'b1;
                pix_wdata.cnt = cnt_q;
                pix_wdata.tm  = t_q;
                if (!found_q && cnt_q < CNT_W'(MAX_ENTRIES)) begin
                  for (int n = 0; n < NCH; n++) begin
                    cw.lhi[n]  = (n < CHANNELS_USED) ? hi[n] : hi[0];
                    cw.llo[n]  = (n < CHANNELS_USED) ? lo[n] : lo[0];
                    cw.bmax[n] = p_q[n];
                    cw.bmin[n] = p_q[n];
                  end
                  cw.lu    = t_q;
                  cw.st    = '0;
                  cw_we    = 1'b1;
                  cw_waddr = {pix_q, cnt_q[ENT_AW-1:0]};
                  cw_wdata = cw;
                  pix_wdata.cnt = cnt_q + 1'b1;
                end
              end
              CMD_CLEAR: begin
                pix_we = 1'b1;
                pix_wdata.cnt = k_q;
                pix_wdata.tm  = '0;
              end
              default: ;
            endcase
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      k_q      <= '0;
      hit_q    <= '0;
      found_q  <= 1'b0;
      fg_q     <= 1'b0;
      t_q      <= '0;
      thresh_q <= '0;
      cmd_q    <= CMD_LEARN;
      skip_q   <= 1'b1;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      k_q      <= k_d;
      hit_q    <= hit_d;
      found_q  <= found_d;
      fg_q     <= fg_d;
      t_q      <= t_d;
      thresh_q <= thresh_d;
      if (in_accept) begin
        cmd_q  <= command_i;
        skip_q <= (32'(pixel_index_i) >= PIXELS) ||
                  !(command_i == CMD_LEARN || command_i == CMD_DETECT ||
                    command_i == CMD_CLEAR);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q  <= pixel_index_i[PIX_AW-1:0];
      p_q[0] <= chan_a_i;
      p_q[1] <= chan_b_i;
      p_q[2] <= chan_c_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] wide_idx, wide_clr;
    wide_idx = '0;
    wide_clr = 32'(cnt_q) - 32'(k_q);
    if (cmd_q == CMD_LEARN && !skip_q) begin
      if (found_q) begin
        wide_idx = 32'(hit_q);
      end else if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
        wide_idx = 32'(cnt_q);
      end
    end
    if (finish) begin
      entry_index_q <= wide_idx[2:0];
      foreground_q  <= !skip_q && cmd_q == CMD_DETECT && fg_q;
      cleared_q     <= (!skip_q && cmd_q == CMD_CLEAR) ? wide_clr[3:0] : 4'd0;
      overflow_q    <= !skip_q && cmd_q == CMD_LEARN && !found_q &&
                       cnt_q >= CNT_W'(MAX_ENTRIES);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_index_o   = entry_index_q;
  assign foreground_o    = foreground_q;
  assign cleared_count_o = cleared_q;
  assign overflow_o      = overflow_q;

  cbm_pix_mem u_pix_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pix_we),
    .waddr_i (pix_q),
    .wdata_i (pix_wdata),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata),
    .ready_o (pix_ready)
  );

  cbm_cw_mem u_cw_mem (
    .clk_i   (clk_i),
    .we_i    (cw_we),
    .waddr_i (cw_waddr),
    .wdata_i (cw_wdata),
    .raddr_i (cw_raddr),
    .rdata_o (cw_rdata)
  );

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("item accepted while busy");
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q < cnt_q)) else $error("scan past codeword count");
  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmd_q == CMD_CLEAR) |-> (k_q <= idx_q))
    else $error("clear write overtook read");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES)) else $error("codeword count out of range");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for codebook_background_model_unit. A queue of pending
// pixel beats feeds a clocked driver; a clocked monitor compares every result
// beat against a behavioural codebook predictor, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cbm_pkg::*;

  // Command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles without any accepted beat or taken result before the run is
  // abandoned. The reset sweep of the pixel store also counts as quiet.
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] px;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
  } pix_beat_t;

  typedef struct packed {
    logic [2:0] entry;
    logic       fg;
    logic [3:0] cleared;
    logic       ovf;
  } res_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [15:0] pixel_index_i = '0;
  logic [7:0]  chan_a_i = '0;
  logic [7:0]  chan_b_i = '0;
  logic [7:0]  chan_c_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  entry_index_o;
  logic        foreground_o;
  logic [3:0]  cleared_count_o;
  logic        overflow_o;

  codebook_background_model_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the register copies and a sparse copy of the codebooks.
  // Codeword stores are keyed by pixel * MAX_ENTRIES + slot.
  logic [7:0]        bound_r = 8'd10;
  logic signed [8:0] min_mod_r = 9'sd10;
  logic signed [8:0] max_mod_r = 9'sd10;
  int unsigned       n_words[int];
  int unsigned       px_clock[int];
  logic [2:0][7:0]   lrn_hi[int];
  logic [2:0][7:0]   lrn_lo[int];
  logic [2:0][7:0]   seen_max[int];
  logic [2:0][7:0]   seen_min[int];
  int unsigned       touched[int];
  int unsigned       stale[int];

  pix_beat_t   pending_beats[$];
  res_beat_t   owed_results[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  logic [7:0]  px_base[int];

  // Works out the result of one beat and advances the codebook copy.
  function automatic res_beat_t codebook_predict(pix_beat_t bt);
    res_beat_t   r;
    int unsigned base, cnt, t, hit, k, run, e, src, dst;
    logic [2:0][7:0] p, hi, lo;
    bit found, all;
    int mn, mx;
    r = '0;
    p = {bt.c, bt.b, bt.a};
    base = bt.px * MAX_ENTRIES;
    if (!n_words.exists(bt.px)) begin
      n_words[bt.px] = 0;
      px_clock[bt.px] = 0;
    end
    cnt = n_words[bt.px];
    found = 1'b0;
    hit = 0;
    case (bt.cmd)
      CMD_LEARN: begin
        // An empty codebook restarts the pixel's time keeping.
        if (cnt == 0) px_clock[bt.px] = 0;
        if (px_clock[bt.px] < 65535) px_clock[bt.px]++;
        t = px_clock[bt.px];
        for (int n = 0; n < 3; n++) begin
          hi[n] = (p[n] + bound_r > 255) ? 8'd255 : p[n] + bound_r;
          lo[n] = (p[n] > bound_r) ? p[n] - bound_r : 8'd0;
        end
        for (int i = 0; i < cnt && !found; i++) begin
          e = base + i;
          all = 1'b1;
          for (int n = 0; n < 3; n++)
            if (!(lrn_lo[e][n] <= p[n] && p[n] <= lrn_hi[e][n])) all = 1'b0;
          if (all) begin
            found = 1'b1;
            hit = i;
            touched[e] = t;
            for (int n = 0; n < 3; n++) begin
              if (seen_max[e][n] < p[n]) seen_max[e][n] = p[n];
              else if (seen_min[e][n] > p[n]) seen_min[e][n] = p[n];
            end
          end
        end
        if (!found) begin
          if (cnt < MAX_ENTRIES) begin
            e = base + cnt;
            lrn_hi[e] = hi;
            lrn_lo[e] = lo;
            seen_max[e] = p;
            seen_min[e] = p;
            touched[e] = t;
            stale[e] = 0;
            hit = cnt;
            cnt++;
            n_words[bt.px] = cnt;
            found = 1'b1;
          end else begin
            r.ovf = 1'b1;
          end
        end
        for (int s = 0; s < cnt; s++) begin
          e = base + s;
          run = (t >= touched[e]) ? t - touched[e] : 0;
          if (stale[e] < run) stale[e] = run;
        end
        if (found) begin
          e = base + hit;
          for (int n = 0; n < 3; n++) begin
            if (lrn_hi[e][n] < hi[n]) lrn_hi[e][n]++;
            if (lrn_lo[e][n] > lo[n]) lrn_lo[e][n]--;
          end
          r.entry = hit[2:0];
        end
      end
      CMD_DETECT: begin
        mn = min_mod_r;
        mx = max_mod_r;
        r.fg = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          e = base + i;
          all = 1'b1;
          for (int n = 0; n < 3; n++)
            if (!(int'(seen_min[e][n]) - mn <= int'(p[n]) &&
                  int'(p[n]) <= int'(seen_max[e][n]) + mx)) all = 1'b0;
          if (all) r.fg = 1'b0;
        end
      end
      CMD_CLEAR: begin
        // Stale codewords drop out and the survivors close up from slot 0.
        k = 0;
        for (int i = 0; i < cnt; i++) begin
          src = base + i;
          dst = base + k;
          if (stale[src] <= (px_clock[bt.px] >> 1)) begin
            lrn_hi[dst] = lrn_hi[src];
            lrn_lo[dst] = lrn_lo[src];
            seen_max[dst] = seen_max[src];
            seen_min[dst] = seen_min[src];
            stale[dst] = 0;
            touched[dst] = 0;
            k++;
          end
        end
        px_clock[bt.px] = 0;
        n_words[bt.px] = k;
        r.cleared = 4'(cnt - k);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: presents queued beats, idling at random between them.
  always @(posedge clk_i) begin
    bit took;
    took = in_valid_i && !in_stall_o;
    if (took) begin
      owed_results.push_back(codebook_predict(pending_beats[0]));
      void'(pending_beats.pop_front());
    end
    if (!in_valid_i || took) begin
      if (pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid_i    <= 1'b1;
        command_i     <= pending_beats[0].cmd;
        pixel_index_i <= pending_beats[0].px;
        chan_a_i      <= pending_beats[0].a;
        chan_b_i      <= pending_beats[0].b;
        chan_c_i      <= pending_beats[0].c;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: takes result beats, checks them and keeps the watchdog.
  always @(posedge clk_i) begin
    res_beat_t want;
    if (out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (entry_index_o !== want.entry) begin
          $display("%0t: entry_index expected %0d got %0d", $time, want.entry,
                   entry_index_o);
          errors++;
        end
        if (foreground_o !== want.fg) begin
          $display("%0t: foreground expected %0d got %0d", $time, want.fg,
                   foreground_o);
          errors++;
        end
        if (cleared_count_o !== want.cleared) begin
          $display("%0t: cleared_count expected %0d got %0d", $time,
                   want.cleared, cleared_count_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %0d got %0d", $time, want.ovf,
                   overflow_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic push_beat(logic [1:0] cmd, logic [15:0] px, logic [7:0] a,
                           logic [7:0] b, logic [7:0] c);
    pending_beats.push_back('{cmd: cmd, px: px, a: a, b: b, c: c});
  endtask

  // Register writes only happen with the block idle, so the predictor copy
  // can be updated at once.
  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_LEARN_BOUND: bound_r = data[7:0];
      REG_MIN_MOD:     min_mod_r = data;
      REG_MAX_MOD:     max_mod_r = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_beats.size() != 0 || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [7:0] near(logic [7:0] centre, int spread);
    int v;
    v = int'(centre) + $urandom_range(0, 2 * spread) - spread;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Random beats concentrated on a few pixels so that codebooks fill up,
  // overflow and get cleared; the channels hover around a per-pixel colour.
  task automatic random_phase(int unsigned count);
    logic [15:0] px;
    logic [1:0]  cmd;
    int unsigned roll, spread;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) px = 16'($urandom_range(0, 65535));
      else if (roll < 14) px = 16'hFFFF;
      else px = 16'($urandom_range(0, 5));
      if (!px_base.exists(px)) px_base[px] = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      cmd = (roll < 58) ? CMD_LEARN : (roll < 88) ? CMD_DETECT :
            (roll < 97) ? CMD_CLEAR : CMD_UNUSED;
      spread = ($urandom_range(0, 3) == 0) ? 128 : 20;
      push_beat(cmd, px, near(px_base[px], spread), near(px_base[px], spread),
                near(px_base[px], spread));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats: empty codebooks, channel extremes, a full codebook
    // with overflow, clear, the unused command and both pixel extremes.
    push_beat(CMD_DETECT, 16'd7, 8'd0, 8'd0, 8'd0);
    push_beat(CMD_LEARN, 16'd0, 8'd0, 8'd0, 8'd0);
    push_beat(CMD_LEARN, 16'hFFFF, 8'd255, 8'd255, 8'd255);
    push_beat(CMD_LEARN, 16'd0, 8'd3, 8'd5, 8'd8);
    push_beat(CMD_DETECT, 16'd0, 8'd12, 8'd0, 8'd0);
    push_beat(CMD_DETECT, 16'hFFFF, 8'd240, 8'd255, 8'd200);
    for (int i = 0; i < 10; i++)
      push_beat(CMD_LEARN, 16'd9, 8'(i * 28), 8'(255 - i * 28), 8'(i * 17));
    push_beat(CMD_LEARN, 16'd9, 8'd0, 8'd0, 8'd0);
    push_beat(CMD_DETECT, 16'd9, 8'd128, 8'd128, 8'd128);
    push_beat(CMD_CLEAR, 16'd9, 8'd0, 8'd0, 8'd0);
    push_beat(CMD_LEARN, 16'd9, 8'd55, 8'd66, 8'd77);
    push_beat(CMD_CLEAR, 16'd7, 8'd0, 8'd0, 8'd0);
    push_beat(CMD_UNUSED, 16'd0, 8'd255, 8'd255, 8'd255);
    push_beat(CMD_DETECT, 16'd0, 8'd3, 8'd5, 8'd8);
    drain();

    // Phases of random traffic, each under its own registers and idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_LEARN_BOUND, 9'd0);
          write_reg(REG_MIN_MOD, -9'sd255);
          write_reg(REG_MAX_MOD, 9'sd255);
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          write_reg(REG_LEARN_BOUND, 9'd255);
          write_reg(REG_MIN_MOD, 9'sd255);
          write_reg(REG_MAX_MOD, -9'sd255);
          idle_pct = 76; stall_pct = 0;
        end
        2: begin
          write_reg(REG_LEARN_BOUND, 9'd10);
          write_reg(REG_MIN_MOD, 9'sd0);
          write_reg(REG_MAX_MOD, 9'sd0);
          idle_pct = 0;  stall_pct = 76;
        end
        3: begin
          write_reg(REG_LEARN_BOUND, 9'($urandom_range(0, 255)));
          write_reg(REG_MIN_MOD, 9'($urandom_range(0, 511)));
          write_reg(REG_MAX_MOD, 9'($urandom_range(0, 511)));
          idle_pct = 24; stall_pct = 24;
        end
        default: begin
          write_reg(REG_LEARN_BOUND, 9'd6);
          write_reg(REG_MIN_MOD, 9'sd12);
          write_reg(REG_MAX_MOD, -9'sd3);
          idle_pct = 0;  stall_pct = 0;
        end
      endcase
      random_phase(205);
      drain();
    end

    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
